/* hdl/fcc_pkg.sv */
package fcc_pkg;

    // Allocation table size in bytes; a power of two from 512 to 8192.
    localparam int TABLE_BYTES = 8192;

    localparam int ADDR_W     = 13;
    localparam int CLUSTER_W  = 12;
    localparam int IDX_W      = CLUSTER_W + 1;
    localparam int BANK_DEPTH = TABLE_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int SPC_W      = 8;
    localparam int START_W    = 16;
    localparam int PROD_W     = CLUSTER_W + SPC_W;
    localparam int LBA_W      = 20;
    localparam int CFG_DATA_W = 16;

    localparam logic [ADDR_W:0]      TABLE_BYTES_W = (ADDR_W + 1)'(TABLE_BYTES);
    localparam logic [CLUSTER_W-1:0] ENTRY_MASK    = 12'hFFF;
    localparam logic [CLUSTER_W-1:0] END_MARK      = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 12'd2;
    localparam logic [LBA_W-1:0]     LBA_MAX       = 20'hFFFFF;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic CFG_DATA_START  = 1'b0;
    localparam logic CFG_SECTORS_PER = 1'b1;

    // Request towards the table banks: one byte write and one entry read.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
    } fcc_req_t;

endpackage

/* hdl/fcc_table.sv */
module fcc_table
    import fcc_pkg::*;
(
    input  logic       clk,
    input  fcc_req_t   req,
    output logic [7:0] lo_byte,
    output logic [7:0] hi_byte
);

    // Even and odd bytes live in separate banks, so the two bytes of an
    // entry are read in the same cycle with one port on each bank.
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    logic [7:0]         even_q_reg;
    logic [7:0]         odd_q_reg;
    logic               idx_odd_reg;
    logic [IDX_W-2:0]   base;
    logic [IDX_W-2:0]   base_inc;
    logic [BANK_AW-1:0] even_rd_addr;
    logic [BANK_AW-1:0] odd_rd_addr;
    logic [BANK_AW-1:0] wr_bank_addr;

    assign base         = req.rd_idx[IDX_W-1:1];
    assign base_inc     = base + {{(IDX_W-2){1'b0}}, 1'b1};
    assign even_rd_addr = req.rd_idx[0] ? BANK_AW'(base_inc) : BANK_AW'(base);
    assign odd_rd_addr  = BANK_AW'(base);
    assign wr_bank_addr = BANK_AW'(req.wr_addr[ADDR_W-1:1]);

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.wr_addr[0])
        begin
            even_mem[wr_bank_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            even_q_reg <= even_mem[even_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en && req.wr_addr[0])
        begin
            odd_mem[wr_bank_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            odd_q_reg   <= odd_mem[odd_rd_addr];
            idx_odd_reg <= req.rd_idx[0];
        end
    end

    assign lo_byte = idx_odd_reg ? odd_q_reg : even_q_reg;
    assign hi_byte = idx_odd_reg ? even_q_reg : odd_q_reg;

endmodule

/* hdl/fcc_lba.sv */
module fcc_lba
    import fcc_pkg::*;
(
    input  logic                 clk,
    input  logic [CLUSTER_W-1:0] cluster_off,
    input  logic [SPC_W-1:0]     sectors_per,
    input  logic [START_W-1:0]   data_start,
    input  logic                 clear,
    output logic [LBA_W-1:0]     sector_lba
);

    logic [PROD_W-1:0]  prod_reg;
    logic [LBA_W-1:0]   lba_reg;
    logic [LBA_W-1:0]   lba_next;
    logic [PROD_W:0]    sum;

    assign sum = {1'b0, prod_reg} + (PROD_W + 1)'(data_start);

    always_comb
    begin
        if (clear)
        begin
            lba_next = '0;
        end
        else if (sum > (PROD_W + 1)'(LBA_MAX))
        begin
            lba_next = LBA_MAX;
        end
        else
        begin
            lba_next = LBA_W'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(cluster_off) * PROD_W'(sectors_per);
        lba_reg  <= lba_next;
    end

    assign sector_lba = lba_reg;

endmodule

/* hdl/fat12_cluster_chain_step_top.sv */
// FAT12 cluster chain step.
//
// Software loads a byte copy of the FAT12 allocation table with write
// requests (mode low, table_address, table_byte) and then walks a chain with
// lookup requests (mode high, cluster). A request is taken at a rising edge
// where start is high and busy is low; busy stays low, so a request may be
// issued in every cycle, writes and lookups mixed in any order.
// Each lookup that is taken produces one result: done is
// high for exactly one cycle with sector_lba, next_cluster, end_of_chain and
// bad_cluster valid alongside it. Writes produce no result. The receiver
// cannot stall, so results follow requests in order at one per cycle.
// The sustained rate is one request per cycle; each lookup passes through
// the registered table read, the registered multiplier and the final
// add-and-saturate stage.
// The two configuration registers (data_start_lba, sectors_per_cluster) are
// written through cfg_write, cfg_index and cfg_data while no lookup is in
// flight. Reset returns them to 0 and 1 and empties the pipeline; the table
// contents are not cleared and must be written before they are looked up.
module fat12_cluster_chain_step_top
    import fcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [ADDR_W-1:0]     table_address,
    input  logic [7:0]            table_byte,
    input  logic [CLUSTER_W-1:0]  cluster,
    output logic                  done,
    output logic [LBA_W-1:0]      sector_lba,
    output logic [CLUSTER_W-1:0]  next_cluster,
    output logic                  end_of_chain,
    output logic                  bad_cluster,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [START_W-1:0] data_start_reg;
    logic [SPC_W-1:0]   spc_reg;

    // Stage 0 is the request itself: the table is written or read at the
    // edge that takes the request, and the lookup checks are formed here.
    logic               accept;
    logic               lookup;
    logic [IDX_W-1:0]   entry_idx;
    logic [IDX_W:0]     entry_end;
    logic               entry_bad;
    fcc_req_t           table_req;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;

    // Stage 1: table bytes are in the table's read registers.
    logic                 s1_valid_reg;
    logic                 s1_bad_reg;
    logic                 s1_odd_reg;
    logic [CLUSTER_W-1:0] s1_off_reg;
    logic [15:0]          s1_word;
    logic [CLUSTER_W-1:0] s1_entry;

    // Stage 2: product and entry are registered.
    logic                 s2_valid_reg;
    logic                 s2_bad_reg;
    logic [CLUSTER_W-1:0] s2_entry_reg;

    // Stage 3: result registers.
    logic                 done_reg;
    logic [CLUSTER_W-1:0] next_cluster_reg;
    logic                 end_reg;
    logic                 bad_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign lookup = accept && (mode == MODE_LOOKUP);

    // Byte index of the entry is cluster * 3 / 2.
    assign entry_idx = {1'b0, cluster} + {2'b00, cluster[CLUSTER_W-1:1]};
    assign entry_end = {1'b0, entry_idx} + (IDX_W + 1)'(1);
    assign entry_bad = (cluster < FIRST_CLUSTER) ||
                       (entry_end >= (IDX_W + 1)'(TABLE_BYTES_W));

    always_comb
    begin
        table_req.wr_en   = accept && (mode == MODE_WRITE) &&
                            ({1'b0, table_address} < TABLE_BYTES_W);
        table_req.wr_addr = table_address;
        table_req.wr_data = table_byte;
        table_req.rd_en   = lookup;
        table_req.rd_idx  = entry_idx;
    end

    fcc_table u_table (
        .clk     (clk),
        .req     (table_req),
        .lo_byte (lo_byte),
        .hi_byte (hi_byte)
    );

    // Configuration writes must wait for an empty pipeline; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= '0;
            spc_reg        <= SPC_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DATA_START:  data_start_reg <= cfg_data[START_W-1:0];
                CFG_SECTORS_PER: spc_reg        <= cfg_data[SPC_W-1:0];
                default:         data_start_reg <= data_start_reg;
            endcase
        end
    end

    // Valid bits travel down the pipeline alongside the payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= lookup;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // An even cluster keeps the low twelve bits of the little-endian word,
    // an odd cluster takes the upper twelve.
    assign s1_word  = {hi_byte, lo_byte};
    assign s1_entry = s1_odd_reg ? s1_word[15:4] : (s1_word[11:0] & ENTRY_MASK);

    always_ff @(posedge clk)
    begin
        s1_bad_reg       <= entry_bad;
        s1_odd_reg       <= cluster[0];
        s1_off_reg       <= cluster - FIRST_CLUSTER;
        s2_bad_reg       <= s1_bad_reg;
        s2_entry_reg     <= s1_bad_reg ? '0 : s1_entry;
        next_cluster_reg <= s2_entry_reg;
        end_reg          <= (s2_entry_reg >= END_MARK);
        bad_reg          <= s2_bad_reg;
    end

    // Sector number: the multiply sits between stages 1 and 2, the add
    // and saturation between stages 2 and 3. A bad cluster forces zero.
    fcc_lba u_lba (
        .clk         (clk),
        .cluster_off (s1_off_reg),
        .sectors_per (spc_reg),
        .data_start  (data_start_reg),
        .clear       (s2_bad_reg),
        .sector_lba  (sector_lba)
    );

    assign done         = done_reg;
    assign next_cluster = next_cluster_reg;
    assign end_of_chain = end_reg;
    assign bad_cluster  = bad_reg;

endmodule

/* hdl/fcc_checker.sv */
module fcc_checker
    import fcc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  mode,
    input logic                  done,
    input logic [LBA_W-1:0]      sector_lba,
    input logic [CLUSTER_W-1:0]  next_cluster,
    input logic                  end_of_chain,
    input logic                  bad_cluster
);

    logic lookup_taken;
    logic write_taken;

    assign lookup_taken = start && !busy && (mode == MODE_LOOKUP);
    assign write_taken  = start && !busy && (mode == MODE_WRITE);

    // Every lookup produces a result.
    a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_taken |-> ##3 done)
        else $error("lookup request without a result");

    // A write produces no result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        write_taken |-> ##3 !done)
        else $error("write request produced a result");

    // A result always stems from an earlier lookup.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(lookup_taken, 3))
        else $error("result without a matching lookup");

    // A bad cluster reports all other fields as zero.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_cluster) |->
            (sector_lba == '0) && (next_cluster == '0) && !end_of_chain)
        else $error("bad cluster result carries non-zero fields");

    // The end flag agrees with the next cluster.
    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (end_of_chain == (next_cluster >= END_MARK)))
        else $error("end of chain flag disagrees with next cluster");

endmodule

bind fat12_cluster_chain_step_top fcc_checker u_fcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .done         (done),
    .sector_lba   (sector_lba),
    .next_cluster (next_cluster),
    .end_of_chain (end_of_chain),
    .bad_cluster  (bad_cluster)
);
